// ===== design/assert_macros.svh =====
// Assertion macros for the execute stage RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/mae_pkg.sv =====
// ----------------------------------------------------------------------------
// mae_pkg
// Types and codes for the MIPS-like ALU execute stage.
// ----------------------------------------------------------------------------
package mae_pkg;

   // Primary opcodes
   localparam logic [5:0] OP_RTYPE  = 6'd0;
   localparam logic [5:0] OP_J      = 6'd2;
   localparam logic [5:0] OP_JAL    = 6'd3;
   localparam logic [5:0] OP_BEQ    = 6'd4;
   localparam logic [5:0] OP_BNE    = 6'd5;
   localparam logic [5:0] OP_BGTZ   = 6'd7;
   localparam logic [5:0] OP_ADDI   = 6'd8;
   localparam logic [5:0] OP_ADDIU  = 6'd9;
   localparam logic [5:0] OP_SLTI   = 6'd10;
   localparam logic [5:0] OP_ANDI   = 6'd12;
   localparam logic [5:0] OP_ORI    = 6'd13;
   localparam logic [5:0] OP_NORI   = 6'd14;
   localparam logic [5:0] OP_LUI    = 6'd15;
   localparam logic [5:0] OP_LB     = 6'd32;
   localparam logic [5:0] OP_LH     = 6'd33;
   localparam logic [5:0] OP_LW     = 6'd35;
   localparam logic [5:0] OP_LBU    = 6'd36;
   localparam logic [5:0] OP_LHU    = 6'd37;
   localparam logic [5:0] OP_SB     = 6'd40;
   localparam logic [5:0] OP_SH     = 6'd41;
   localparam logic [5:0] OP_SW     = 6'd43;
   localparam logic [5:0] OP_FINISH = 6'd63;

   // Function codes of the register-register group
   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_SRA  = 6'd3;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_XOR  = 6'd38;
   localparam logic [5:0] FN_NOR  = 6'd39;
   localparam logic [5:0] FN_NAND = 6'd40;
   localparam logic [5:0] FN_SLT  = 6'd42;

   // Memory access marks
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_FINISH  = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam int unsigned LUI_SHIFT = 16;

   typedef struct packed {
      logic [5:0]         opcode;
      logic [5:0]         func;
      logic [4:0]         shamt;
      logic signed [15:0] imm16;
      logic [31:0]        rs_value;
      logic [31:0]        rt_value;
   } req_type;

   typedef struct packed {
      logic [31:0] alu_result;
      logic        writes_result;
      logic [1:0]  mem_access;
      logic        overflow;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== design/mips_alu_execute.sv =====
// ----------------------------------------------------------------------------
// mips_alu_execute
// Execute stage of a MIPS-like pipeline: ALU ops, shifts, compares and
// load/store address generation with signed overflow and status.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------
//   req      | in        | req_valid/req_ready  | req_data (req_type)
//   rsp      | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// One item per cycle sustained while rsp_ready is high; an accepted item
// passes the input register, the ALU and the result register before
// rsp_valid rises, and a stall on rsp can hold it in either register.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on rsp holds the result register and, once the input register
// is also full, drops req_ready; each stage moves forward as soon as the
// stage ahead of it frees up or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mips_alu_execute import mae_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Input register
   logic    in_vld_ff;
   logic    in_vld_in;
   req_type in_data_ff;

   // Result register
   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_data_ff;

   rsp_type alu_res;
   logic    advance;
   logic    take_req;

   mae_alu u_alu (
      .op_in   (in_data_ff),
      .res_out (alu_res)
   );

   // Move the computed item into the result register when it is empty
   // or being taken this cycle.
   assign advance   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;
   assign take_req  = req_valid & req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take_req) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers: load on their stage's transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= alu_res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   `ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp_valid after reset")
   `ASSERT_CLK(a_stall_keeps_item, in_vld_ff && out_vld_ff && !rsp_ready |=> in_vld_ff, "item lost in input register during stall")
   `ASSERT_CLK(a_mem_writes, rsp_valid && rsp_data.mem_access != MEM_NONE |-> rsp_data.writes_result, "memory access without address result")
   `ASSERT_CLK(a_nonnormal_empty, rsp_valid && rsp_data.status != ST_NORMAL |-> !rsp_data.writes_result && !rsp_data.overflow && rsp_data.alu_result == 32'd0, "finish or unknown item carries a value")

endmodule

// ===== design/mae_alu.sv =====
// ----------------------------------------------------------------------------
// mae_alu
// Single-pass ALU and decode: one instruction in, one result item out.
// ----------------------------------------------------------------------------
module mae_alu import mae_pkg::*; (
   input  req_type op_in,
   output rsp_type res_out
);

   logic [31:0] imm_sx;
   logic [31:0] imm_zx;
   logic [31:0] add_b;
   logic [31:0] sum;
   logic        add_ovf;
   logic        r_slt;
   logic        i_slt;

   assign imm_sx = {{16{op_in.imm16[15]}}, op_in.imm16};
   assign imm_zx = {16'd0, op_in.imm16};

   // One shared adder: rs plus rt, minus rt, or the sign-extended immediate
   always_comb begin
      add_b = imm_sx;
      if (op_in.opcode == OP_RTYPE) begin
         if (op_in.func == FN_SUB) begin
            add_b = 32'd0 - op_in.rt_value;
         end else begin
            add_b = op_in.rt_value;
         end
      end
   end

   assign sum     = op_in.rs_value + add_b;
   assign add_ovf = ~(op_in.rs_value[31] ^ add_b[31]) & (op_in.rs_value[31] ^ sum[31]);
   assign r_slt   = $signed(op_in.rs_value) < $signed(op_in.rt_value);
   assign i_slt   = $signed(op_in.rs_value) < $signed(imm_sx);

   always_comb begin
      res_out.alu_result    = 32'd0;
      res_out.writes_result = 1'b1;
      res_out.mem_access    = MEM_NONE;
      res_out.overflow      = 1'b0;
      res_out.status        = ST_NORMAL;
      if (op_in.opcode == OP_RTYPE) begin
         case (op_in.func)
            FN_ADD: begin
               res_out.alu_result = sum;
               res_out.overflow   = add_ovf;
            end
            FN_ADDU: res_out.alu_result = sum;
            FN_SUB: begin
               res_out.alu_result = sum;
               res_out.overflow   = add_ovf;
            end
            FN_AND:  res_out.alu_result = op_in.rs_value & op_in.rt_value;
            FN_OR:   res_out.alu_result = op_in.rs_value | op_in.rt_value;
            FN_XOR:  res_out.alu_result = op_in.rs_value ^ op_in.rt_value;
            FN_NOR:  res_out.alu_result = ~(op_in.rs_value | op_in.rt_value);
            FN_NAND: res_out.alu_result = ~(op_in.rs_value & op_in.rt_value);
            FN_SLT:  res_out.alu_result = {31'd0, r_slt};
            FN_SLL:  res_out.alu_result = op_in.rt_value << op_in.shamt;
            FN_SRL:  res_out.alu_result = op_in.rt_value >> op_in.shamt;
            FN_SRA:  res_out.alu_result = 32'($signed(op_in.rt_value) >>> op_in.shamt);
            FN_JR:   res_out.writes_result = 1'b0;
            default: begin
               res_out.writes_result = 1'b0;
               res_out.status        = ST_UNKNOWN;
            end
         endcase
      end else begin
         case (op_in.opcode)
            OP_ADDI: begin
               res_out.alu_result = sum;
               res_out.overflow   = add_ovf;
            end
            OP_ADDIU: res_out.alu_result = sum;
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
               res_out.alu_result = sum;
               res_out.overflow   = add_ovf;
               res_out.mem_access = MEM_LOAD;
            end
            OP_SB, OP_SH, OP_SW: begin
               res_out.alu_result = sum;
               res_out.overflow   = add_ovf;
               res_out.mem_access = MEM_STORE;
            end
            OP_LUI:  res_out.alu_result = imm_zx << LUI_SHIFT;
            OP_ANDI: res_out.alu_result = op_in.rs_value & imm_zx;
            OP_ORI:  res_out.alu_result = op_in.rs_value | imm_zx;
            OP_NORI: res_out.alu_result = ~(op_in.rs_value | imm_zx);
            OP_SLTI: res_out.alu_result = {31'd0, i_slt};
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ: res_out.writes_result = 1'b0;
            OP_FINISH: begin
               res_out.writes_result = 1'b0;
               res_out.status        = ST_FINISH;
            end
            default: begin
               res_out.writes_result = 1'b0;
               res_out.status        = ST_UNKNOWN;
            end
         endcase
      end
   end

endmodule

// ===== verif/exec_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exec_scoreboard_pkg
// Result tracking for the execute stage bench: computes the result each
// accepted instruction must produce and compares it against what the stage
// returns, in order.
// ----------------------------------------------------------------------------
package exec_scoreboard_pkg;
   import mae_pkg::*;

   class exec_scoreboard;
      rsp_type     pending_results[$];
      int unsigned instrs_noted;
      int unsigned results_checked;
      int unsigned failures;
      int unsigned overflow_seen;
      int unsigned mem_ops_seen;
      int unsigned status_events;

      function new();
         instrs_noted    = 0;
         results_checked = 0;
         failures        = 0;
         overflow_seen   = 0;
         mem_ops_seen    = 0;
         status_events   = 0;
      endfunction

      // Signed overflow of a 32-bit add: same-sign addends, other-sign sum.
      static function logic add_overflows(logic [31:0] a, logic [31:0] b);
         logic [31:0] sum;
         sum = a + b;
         return (a[31] == b[31]) && (sum[31] != a[31]);
      endfunction

      static function rsp_type compute_alu(req_type r);
         rsp_type     o;
         logic [31:0] sx_imm;
         logic [31:0] zx_imm;
         logic [31:0] neg_rt;
         o               = '0;
         o.writes_result = 1'b1;
         o.mem_access    = MEM_NONE;
         o.status        = ST_NORMAL;
         sx_imm = {{16{r.imm16[15]}}, r.imm16};
         zx_imm = {16'h0000, r.imm16};
         neg_rt = 32'd0 - r.rt_value;
         if (r.opcode == OP_RTYPE) begin
            case (r.func)
               FN_ADD: begin
                  o.overflow   = add_overflows(r.rs_value, r.rt_value);
                  o.alu_result = r.rs_value + r.rt_value;
               end
               FN_ADDU: o.alu_result = r.rs_value + r.rt_value;
               // sub is an add of the negated operand, overflow included
               FN_SUB: begin
                  o.overflow   = add_overflows(r.rs_value, neg_rt);
                  o.alu_result = r.rs_value + neg_rt;
               end
               FN_AND:  o.alu_result = r.rs_value & r.rt_value;
               FN_OR:   o.alu_result = r.rs_value | r.rt_value;
               FN_XOR:  o.alu_result = r.rs_value ^ r.rt_value;
               FN_NOR:  o.alu_result = ~(r.rs_value | r.rt_value);
               FN_NAND: o.alu_result = ~(r.rs_value & r.rt_value);
               FN_SLT:  o.alu_result = ($signed(r.rs_value) < $signed(r.rt_value)) ? 32'd1 : 32'd0;
               FN_SLL:  o.alu_result = r.rt_value << r.shamt;
               FN_SRL:  o.alu_result = r.rt_value >> r.shamt;
               FN_SRA:  o.alu_result = $signed(r.rt_value) >>> r.shamt;
               FN_JR:   o.writes_result = 1'b0;
               default: begin
                  o.writes_result = 1'b0;
                  o.status        = ST_UNKNOWN;
               end
            endcase
         end else begin
            case (r.opcode)
               OP_ADDI: begin
                  o.overflow   = add_overflows(r.rs_value, sx_imm);
                  o.alu_result = r.rs_value + sx_imm;
               end
               OP_ADDIU: o.alu_result = r.rs_value + sx_imm;
               OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                  o.overflow   = add_overflows(r.rs_value, sx_imm);
                  o.alu_result = r.rs_value + sx_imm;
                  o.mem_access = MEM_LOAD;
               end
               OP_SB, OP_SH, OP_SW: begin
                  o.overflow   = add_overflows(r.rs_value, sx_imm);
                  o.alu_result = r.rs_value + sx_imm;
                  o.mem_access = MEM_STORE;
               end
               OP_LUI:  o.alu_result = zx_imm << LUI_SHIFT;
               OP_ANDI: o.alu_result = r.rs_value & zx_imm;
               OP_ORI:  o.alu_result = r.rs_value | zx_imm;
               OP_NORI: o.alu_result = ~(r.rs_value | zx_imm);
               OP_SLTI: o.alu_result = ($signed(r.rs_value) < $signed(sx_imm)) ? 32'd1 : 32'd0;
               OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ: o.writes_result = 1'b0;
               OP_FINISH: begin
                  o.writes_result = 1'b0;
                  o.status        = ST_FINISH;
               end
               default: begin
                  o.writes_result = 1'b0;
                  o.status        = ST_UNKNOWN;
               end
            endcase
         end
         return o;
      endfunction

      function void note_instr(req_type r);
         pending_results.push_back(compute_alu(r));
         instrs_noted++;
      endfunction

      function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         bit      ok;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         ok = 1'b1;
         ok &= field_ok("alu_result", want.alu_result, got.alu_result);
         ok &= field_ok("writes_result", 32'(want.writes_result), 32'(got.writes_result));
         ok &= field_ok("mem_access", 32'(want.mem_access), 32'(got.mem_access));
         ok &= field_ok("overflow", 32'(want.overflow), 32'(got.overflow));
         ok &= field_ok("status", 32'(want.status), 32'(got.status));
         if (!ok) failures++;
         results_checked++;
         if (want.overflow) overflow_seen++;
         if (want.mem_access != MEM_NONE) mem_ops_seen++;
         if (want.status != ST_NORMAL) status_events++;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the MIPS-like execute stage. A directed set hits every function
// code, each opcode class and the overflow, finish and unknown-code corners;
// random instructions then run under several handshake idle/stall mixes,
// a long result hold-off that backs up the pipe, and drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import mae_pkg::*;
   import exec_scoreboard_pkg::*;

   localparam int unsigned HALF_PERIOD    = 6;
   localparam int unsigned PHASE_ITEMS    = 275;
   localparam int unsigned BURST_ITEMS    = 40;
   localparam int unsigned HOLDOFF_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES  = 4;
   // Far beyond the slowest legal run.
   localparam longint unsigned TIMEOUT_NS = 64'd400_000 * 12;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Per-cycle idle chances (percent) for each side of the stage.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Hold-off requests: the stimulus bumps the count, the receiver acts on it.
   int unsigned holdoff_asks = 0;
   int unsigned holdoff_seen = 0;
   int unsigned holdoff_left = 0;

   exec_scoreboard board;

   mips_alu_execute u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Result side: random stalls, or a long solid hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_asks != holdoff_seen) begin
         holdoff_seen = holdoff_asks;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Observe both handshakes; values here are the ones before this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (req_valid && req_ready) board.note_instr(req_data);
      end
   end

   // Offer one instruction, idling first at random; return once it is taken.
   // valid is left high so a back-to-back item needs no extra edge.
   task automatic send_item(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_fields(input logic [5:0] opcode, input logic [5:0] func,
                              input logic [4:0] shamt, input logic [15:0] imm,
                              input logic [31:0] rs, input logic [31:0] rt);
      req_type r;
      r.opcode   = opcode;
      r.func     = func;
      r.shamt    = shamt;
      r.imm16    = imm;
      r.rs_value = rs;
      r.rt_value = rt;
      send_item(r);
   endtask

   // Drop valid, then wait for every outstanding result and let the stage settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_imm();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [5:0] pick_func();
      case ($urandom_range(12))
         0:  return FN_ADD;
         1:  return FN_ADDU;
         2:  return FN_SUB;
         3:  return FN_AND;
         4:  return FN_OR;
         5:  return FN_XOR;
         6:  return FN_NOR;
         7:  return FN_NAND;
         8:  return FN_SLT;
         9:  return FN_SLL;
         10: return FN_SRL;
         11: return FN_SRA;
         default: return FN_JR;
      endcase
   endfunction

   function automatic logic [5:0] pick_opcode();
      case ($urandom_range(19))
         0:  return OP_J;
         1:  return OP_JAL;
         2:  return OP_BEQ;
         3:  return OP_BNE;
         4:  return OP_BGTZ;
         5:  return OP_ADDI;
         6:  return OP_ADDIU;
         7:  return OP_SLTI;
         8:  return OP_ANDI;
         9:  return OP_ORI;
         10: return OP_NORI;
         11: return OP_LUI;
         12: return OP_LB;
         13: return OP_LH;
         14: return OP_LW;
         15: return OP_LBU;
         16: return OP_LHU;
         17: return OP_SB;
         18: return OP_SH;
         default: return OP_SW;
      endcase
   endfunction

   // Mostly legal instructions; a slice of raw codes keeps the unknown paths busy.
   function automatic req_type random_instr();
      req_type     r;
      int unsigned pick;
      pick       = $urandom_range(99);
      r.func     = 6'($urandom);
      r.shamt    = 5'($urandom);
      r.imm16    = random_imm();
      r.rs_value = random_word();
      r.rt_value = random_word();
      if (pick < 40) begin
         r.opcode = OP_RTYPE;
         if ($urandom_range(9) != 0) r.func = pick_func();
      end else if (pick < 92) begin
         r.opcode = pick_opcode();
      end else if (pick < 94) begin
         r.opcode = OP_FINISH;
      end else begin
         r.opcode = 6'($urandom);
      end
      return r;
   endfunction

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) send_item(random_instr());
      drain();
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: every function code and opcode class, operand extremes.
      send_fields(OP_RTYPE, FN_ADD,  5'd0,  16'h0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_fields(OP_RTYPE, FN_ADDU, 5'd0,  16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // sub of the most negative value: negation leaves it unchanged
      send_fields(OP_RTYPE, FN_SUB,  5'd0,  16'h0000, 32'hFFFF_FFFF, 32'h8000_0000);
      send_fields(OP_RTYPE, FN_SUB,  5'd0,  16'h0000, 32'h0000_0000, 32'h8000_0000);
      send_fields(OP_RTYPE, FN_AND,  5'd31, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      send_fields(OP_RTYPE, FN_OR,   5'd0,  16'h0000, 32'h0000_0000, 32'h8000_0001);
      send_fields(OP_RTYPE, FN_XOR,  5'd0,  16'h0000, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
      send_fields(OP_RTYPE, FN_NOR,  5'd0,  16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_fields(OP_RTYPE, FN_NAND, 5'd0,  16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(OP_RTYPE, FN_SLT,  5'd0,  16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_fields(OP_RTYPE, FN_SLL,  5'd31, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_fields(OP_RTYPE, FN_SRL,  5'd31, 16'h0000, 32'h0000_0000, 32'h8000_0000);
      send_fields(OP_RTYPE, FN_SRA,  5'd31, 16'h0000, 32'h0000_0000, 32'h8000_0000);
      send_fields(OP_RTYPE, FN_SRA,  5'd0,  16'h0000, 32'h0000_0000, 32'hC000_0001);
      send_fields(OP_RTYPE, FN_JR,   5'd0,  16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(OP_RTYPE, 6'd63,   5'd0,  16'h0000, 32'h1234_5678, 32'h1234_5678);
      send_fields(OP_ADDI,  6'd63,   5'd31, 16'h7FFF, 32'h7FFF_FFFF, 32'h0000_0000);
      send_fields(OP_ADDIU, 6'd0,    5'd0,  16'h8000, 32'h0000_0000, 32'h0000_0000);
      send_fields(OP_SLTI,  6'd0,    5'd0,  16'hFFFF, 32'h8000_0000, 32'h0000_0000);
      // logical immediates take the raw 16 bits, no sign extension
      send_fields(OP_ANDI,  6'd0,    5'd0,  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_fields(OP_ORI,   6'd0,    5'd0,  16'h8000, 32'h0000_0000, 32'h0000_0000);
      send_fields(OP_NORI,  6'd0,    5'd0,  16'hFFFF, 32'h0000_0000, 32'h0000_0000);
      send_fields(OP_LUI,   6'd0,    5'd0,  16'h8000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_fields(OP_LW,    6'd0,    5'd0,  16'hFFFF, 32'h8000_0000, 32'h0000_0000);
      send_fields(OP_SW,    6'd0,    5'd0,  16'h7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_fields(OP_BEQ,   6'd0,    5'd0,  16'h0004, 32'h0000_0001, 32'h0000_0001);
      send_fields(OP_FINISH, 6'd0,   5'd0,  16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_fields(6'd1,     6'd0,    5'd0,  16'h0000, 32'h0000_0000, 32'h0000_0000);
      drain();

      // Random traffic under each idle/stall mix.
      run_phase(0, 0);
      run_phase(87, 0);
      run_phase(0, 87);
      run_phase(22, 22);

      // Back the pipe up: hold off results while the sender keeps pushing.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_asks <= holdoff_asks + 1;
      repeat (BURST_ITEMS) send_item(random_instr());
      drain();

      $display("Execute stage run: %0d instructions in, %0d results compared, %0d failures.",
               board.instrs_noted, board.results_checked, board.failures);
      $display("Covered %0d overflows, %0d loads/stores, %0d finish or unknown-code results.",
               board.overflow_seen, board.mem_ops_seen, board.status_events);
      if (board.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results still outstanding.", board.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/mae_pkg.sv
design/mae_alu.sv
design/mips_alu_execute.sv
verif/exec_scoreboard_pkg.sv
verif/tb_top.sv
